[rtl/core/binary_to_decimal_ascii_unit_macros.svh]
// Assertion macros for the binary to decimal ASCII unit.
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define B2DA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define B2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/b2da_pkg.sv]
// Shared constants, types and conversion functions for the decimal ASCII unit.
package b2da_pkg;

  localparam int ValueW       = 32;
  localparam int NumDigits    = 10;
  localparam int BcdW         = 4 * NumDigits;
  localparam int CharW        = 6;
  localparam int IdxW         = 4;
  localparam int DdStages     = 4;
  localparam int BitsPerStage = ValueW / DdStages;

  localparam logic [CharW-1:0] AsciiZero = 6'd48;

  typedef struct packed {
    logic [BcdW-1:0]   bcd;
    logic [ValueW-1:0] bin;
  } dd_t;

  // One slice of shift-and-add-3 conversion.
  function automatic dd_t dd_step_group(input dd_t a);
    dd_t r;
    r = a;
    for (int s = 0; s < BitsPerStage; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (r.bcd[d*4 +: 4] >= 4'd5) begin
          r.bcd[d*4 +: 4] = r.bcd[d*4 +: 4] + 4'd3;
        end
      end
      r.bcd = {r.bcd[BcdW-2:0], r.bin[ValueW-1]};
      r.bin = {r.bin[ValueW-2:0], 1'b0};
    end
    return r;
  endfunction

  // Index of the most significant non-zero digit, zero for a zero value.
  function automatic logic [IdxW-1:0] top_digit(input logic [BcdW-1:0] bcd);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int d = 1; d < NumDigits; d++) begin
      if (bcd[d*4 +: 4] != 4'd0) begin
        idx = IdxW'(d);
      end
    end
    return idx;
  endfunction

endpackage

[rtl/core/binary_to_decimal_ascii_unit.sv]
// Binary to decimal ASCII unit: pipelined BCD conversion and digit serialiser.
//
// A transaction is taken when start is high and busy is low; in_value is then
// converted over four shift-and-add-3 stages and one leading-digit stage, and
// its decimal digits leave most significant first, one per cycle, on
// out_digit_char with out_valid high, the last one flagged by out_last. Leading
// zeros are dropped; zero gives the single character '0'. The single-character
// output port sets the sustained rate: an item of n digits holds the serialiser
// until all n digits have left, while the conversion stages keep taking new
// items behind it until they fill and busy goes high. Results cannot be held
// off: out_valid is high for exactly one cycle per character and the receiver
// must take it then.
`include "binary_to_decimal_ascii_unit_macros.svh"

module binary_to_decimal_ascii_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [b2da_pkg::ValueW-1:0]  in_value,
  output logic                         busy,
  output logic                         out_valid,
  output logic [b2da_pkg::CharW-1:0]   out_digit_char,
  output logic                         out_last
);
  import b2da_pkg::*;

  logic [DdStages-1:0] dd_v_r;
  dd_t                 dd_r   [DdStages];
  dd_t                 dd_nxt [DdStages];
  logic [DdStages-1:0] dd_rdy;

  logic                cnt_v_r;
  logic [BcdW-1:0]     cnt_bcd_r;
  logic [IdxW-1:0]     cnt_idx_r;
  logic                cnt_rdy;

  logic                ser_v_r;
  logic [BcdW-1:0]     ser_bcd_r;
  logic [IdxW-1:0]     ser_idx_r;
  logic                ser_rdy;
  logic [3:0]          cur_digit;

  logic                out_valid_r;
  logic [CharW-1:0]    out_digit_char_r;
  logic                out_last_r;

  logic                in_acc;

  // Stall chain, back from the serialiser.
  assign ser_rdy = !ser_v_r || (ser_idx_r == '0);
  assign cnt_rdy = !cnt_v_r || ser_rdy;

  always_comb begin
    dd_rdy[DdStages-1] = !dd_v_r[DdStages-1] || cnt_rdy;
    for (int i = DdStages - 2; i >= 0; i--) begin
      dd_rdy[i] = !dd_v_r[i] || dd_rdy[i+1];
    end
  end

  assign busy   = !dd_rdy[0];
  assign in_acc = start && !busy;

  always_comb begin
    dd_nxt[0] = dd_step_group('{bcd: '0, bin: in_value});
    for (int i = 1; i < DdStages; i++) begin
      dd_nxt[i] = dd_step_group(dd_r[i-1]);
    end
  end

  assign cur_digit = ser_bcd_r[ser_idx_r*4 +: 4];

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dd_v_r      <= '0;
      cnt_v_r     <= 1'b0;
      ser_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (dd_rdy[0]) begin
        dd_v_r[0] <= in_acc;
      end
      for (int i = 1; i < DdStages; i++) begin
        if (dd_rdy[i]) begin
          dd_v_r[i] <= dd_v_r[i-1];
        end
      end
      if (cnt_rdy) begin
        cnt_v_r <= dd_v_r[DdStages-1];
      end
      if (ser_rdy) begin
        ser_v_r <= cnt_v_r;
      end
      out_valid_r <= ser_v_r;
    end
  end

  // Data path.
  always_ff @(posedge clk) begin
    if (dd_rdy[0] && in_acc) begin
      dd_r[0] <= dd_nxt[0];
    end
    for (int i = 1; i < DdStages; i++) begin
      if (dd_rdy[i]) begin
        dd_r[i] <= dd_nxt[i];
      end
    end
    if (cnt_rdy) begin
      cnt_bcd_r <= dd_r[DdStages-1].bcd;
      cnt_idx_r <= top_digit(dd_r[DdStages-1].bcd);
    end
    if (ser_rdy) begin
      ser_bcd_r <= cnt_bcd_r;
      ser_idx_r <= cnt_idx_r;
    end else begin
      ser_idx_r <= ser_idx_r - 1'b1;
    end
    out_digit_char_r <= AsciiZero + {{(CharW-4){1'b0}}, cur_digit};
    out_last_r       <= (ser_idx_r == '0);
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_digit_char_r;
  assign out_last       = out_last_r;

  `B2DA_ASSERT_NEXT(a_accept_lands, start && !busy, dd_v_r[0], "transaction not captured")
  `B2DA_ASSERT_NEXT(a_run_contiguous, out_valid_r && !out_last_r, out_valid_r, "digit run broken")
  `B2DA_ASSERT_NEXT(a_idx_steps, ser_v_r && ser_idx_r != '0, ser_v_r && ser_idx_r == $past(ser_idx_r) - 1'b1, "serialiser index slipped")
  `B2DA_ASSERT_NOW(a_no_lead_zero, cnt_v_r && cnt_idx_r != '0, cnt_bcd_r[cnt_idx_r*4 +: 4] != 4'd0, "leading zero kept")

endmodule
